FILE: sv/jsu_pkg.sv
// types, constants and helper functions for the json string unescaper
// no dependencies; used by the unescaper top level
package jsu_pkg;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESCAPE = 2'd1,
        MODE_HEX    = 2'd2
    } t_mode;

    typedef struct packed {
        logic       ok;
        logic [3:0] nibble;
    } t_hex;

    localparam logic [7:0] CHAR_QUOTE  = 8'h22;
    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_SLASH  = 8'h2F;
    localparam logic [7:0] CHAR_U      = 8'h75;
    localparam logic [7:0] CHAR_B      = 8'h62;
    localparam logic [7:0] CHAR_F      = 8'h66;
    localparam logic [7:0] CHAR_N      = 8'h6E;
    localparam logic [7:0] CHAR_R      = 8'h72;
    localparam logic [7:0] CHAR_T      = 8'h74;

    localparam logic [7:0] CTRL_BS = 8'h08;
    localparam logic [7:0] CTRL_FF = 8'h0C;
    localparam logic [7:0] CTRL_LF = 8'h0A;
    localparam logic [7:0] CTRL_CR = 8'h0D;
    localparam logic [7:0] CTRL_HT = 8'h09;

    localparam logic [7:0] UNKNOWN_ESC_RESET = 8'h3F;

    function automatic t_hex hex_value(input logic [7:0] c);
        t_hex h;
        h.ok     = 1'b1;
        h.nibble = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.nibble = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            h.nibble = c[3:0] + 4'd9;
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    function automatic logic [7:0] map_escape(input logic [7:0] c, input logic [7:0] unknown);
        logic [7:0] b;
        case (c)
            CHAR_QUOTE, CHAR_BSLASH, CHAR_SLASH: b = c;
            CHAR_B:  b = CTRL_BS;
            CHAR_F:  b = CTRL_FF;
            CHAR_N:  b = CTRL_LF;
            CHAR_R:  b = CTRL_CR;
            CHAR_T:  b = CTRL_HT;
            default: b = unknown;
        endcase
        return b;
    endfunction

endpackage

FILE: sv/jsu_if.sv
// valid/ready stream interfaces for the unescaper input and result channels
// no dependencies
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_end;
    logic       bad_hex;
    logic       last;

    modport source (output valid, output out_byte, output byte_valid, output string_end,
                    output bad_hex, output last, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input string_end,
                    input bad_hex, input last, output ready);
endinterface

FILE: sv/json_string_unescaper.sv
// json string body unescaper: escapes, \u to utf-8, end-of-string marker
// depends on jsu_pkg and the stream interfaces in jsu_if
//
// usage:
//   i_in takes one raw byte of the string body per transaction, starting
//   after the opening quote. o_out gives the decoded bytes, one result per
//   transaction, with last high on the final result of each input byte.
//   a closing quote gives a result with byte_valid low and string_end high.
//   escaping backslashes, the u of \u and the first three hex digits give no result.
//   i_cfg_we/i_cfg_data write the replacement byte for unknown escapes;
//   write only while the block is idle.
// timing:
//   a byte is registered in the input register, and its results then in the
//   result register. one byte per cycle is sustained while o_out.ready is
//   high; a \u that expands to two or three utf-8 bytes holds the input
//   until its group has drained, since the result port moves one byte per
//   cycle.
// reset: synchronous, active low; clears the decode state and both
//   registers' valid flags, the replacement byte returns to '?'.
// stall: while o_out.ready is low the result holds, the input register
//   fills and then i_in.ready drops.
module json_string_unescaper (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_data,
    jsu_in_if.sink        i_in,
    jsu_out_if.source     o_out
);

    logic [7:0]     r_unknown;

    logic           r_in_vld;
    logic [7:0]     r_in_byte;

    jsu_pkg::t_mode r_mode, n_mode;
    logic [1:0]     r_digits, n_digits;
    logic [15:0]    r_acc, n_acc;
    logic           r_err, n_err;

    logic [1:0]     r_gcnt, n_gcnt;
    logic [7:0]     r_b0, r_b1, r_b2;
    logic [7:0]     n_b0, n_b1, n_b2;
    logic           r_gdata, n_gdata;
    logic           r_gend, n_gend;
    logic           r_gbad, n_gbad;

    jsu_pkg::t_hex  hv;
    logic [15:0]    cp;
    logic           bad;
    logic           out_fire;
    logic           grp_free;
    logic           adv;

    assign hv  = jsu_pkg::hex_value(r_in_byte);
    assign cp  = {r_acc[11:0], hv.nibble};
    assign bad = r_err | ~hv.ok;

    assign out_fire = o_out.valid && o_out.ready;
    assign grp_free = (r_gcnt == 2'd0) || (out_fire && r_gcnt == 2'd1);
    assign adv      = r_in_vld && (grp_free || n_gcnt == 2'd0);

    assign i_in.ready = !r_in_vld || adv;

    assign o_out.valid      = (r_gcnt != 2'd0);
    assign o_out.out_byte   = r_b0;
    assign o_out.byte_valid = r_gdata;
    assign o_out.string_end = r_gend;
    assign o_out.bad_hex    = r_gbad;
    assign o_out.last       = (r_gcnt == 2'd1);

    // decode state
    always_comb begin
        n_mode   = r_mode;
        n_digits = r_digits;
        n_acc    = r_acc;
        n_err    = r_err;
        case (r_mode)
            jsu_pkg::MODE_ESCAPE: begin
                n_digits = 2'd0;
                n_acc    = 16'd0;
                n_err    = 1'b0;
                n_mode   = (r_in_byte == jsu_pkg::CHAR_U) ? jsu_pkg::MODE_HEX
                                                          : jsu_pkg::MODE_NORMAL;
            end
            jsu_pkg::MODE_HEX: begin
                if (r_digits != 2'd3) begin
                    n_digits = r_digits + 2'd1;
                    n_acc    = cp;
                    n_err    = bad;
                end else begin
                    n_mode   = jsu_pkg::MODE_NORMAL;
                    n_digits = 2'd0;
                    n_acc    = 16'd0;
                    n_err    = 1'b0;
                end
            end
            default: begin
                n_mode = (r_in_byte == jsu_pkg::CHAR_BSLASH) ? jsu_pkg::MODE_ESCAPE
                                                             : jsu_pkg::MODE_NORMAL;
            end
        endcase
    end

    // result group for the byte in the input register
    always_comb begin
        n_gcnt  = 2'd0;
        n_b0    = r_in_byte;
        n_b1    = 8'd0;
        n_b2    = 8'd0;
        n_gdata = 1'b1;
        n_gend  = 1'b0;
        n_gbad  = 1'b0;
        case (r_mode)
            jsu_pkg::MODE_ESCAPE: begin
                if (r_in_byte != jsu_pkg::CHAR_U) begin
                    n_gcnt = 2'd1;
                    n_b0   = jsu_pkg::map_escape(r_in_byte, r_unknown);
                end
            end
            jsu_pkg::MODE_HEX: begin
                n_gbad = bad;
                if (r_digits == 2'd3) begin
                    if (cp[15:7] == 9'd0) begin
                        n_gcnt = 2'd1;
                        n_b0   = cp[7:0];
                    end else if (cp[15:11] == 5'd0) begin
                        n_gcnt = 2'd2;
                        n_b0   = {3'b110, cp[10:6]};
                        n_b1   = {2'b10, cp[5:0]};
                    end else begin
                        n_gcnt = 2'd3;
                        n_b0   = {4'hE, cp[15:12]};
                        n_b1   = {2'b10, cp[11:6]};
                        n_b2   = {2'b10, cp[5:0]};
                    end
                end
            end
            default: begin
                if (r_in_byte == jsu_pkg::CHAR_QUOTE) begin
                    n_gcnt  = 2'd1;
                    n_b0    = 8'd0;
                    n_gdata = 1'b0;
                    n_gend  = 1'b1;
                end else if (r_in_byte != jsu_pkg::CHAR_BSLASH) begin
                    n_gcnt = 2'd1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unknown <= jsu_pkg::UNKNOWN_ESC_RESET;
        end else if (i_cfg_we) begin
            r_unknown <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= jsu_pkg::MODE_NORMAL;
            r_digits <= 2'd0;
            r_acc    <= 16'd0;
            r_err    <= 1'b0;
        end else if (adv) begin
            r_mode   <= n_mode;
            r_digits <= n_digits;
            r_acc    <= n_acc;
            r_err    <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gcnt <= 2'd0;
        end else if (adv && n_gcnt != 2'd0) begin
            r_gcnt <= n_gcnt;
        end else if (out_fire) begin
            r_gcnt <= r_gcnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && n_gcnt != 2'd0) begin
            r_b0    <= n_b0;
            r_b1    <= n_b1;
            r_b2    <= n_b2;
            r_gdata <= n_gdata;
            r_gend  <= n_gend;
            r_gbad  <= n_gbad;
        end else if (out_fire) begin
            r_b0 <= r_b1;
            r_b1 <= r_b2;
        end
    end

`ifndef SYNTHESIS
    a_stall_holds_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> $stable(r_gcnt) && $stable(r_b0))
        else $error("result group changed under stall");

    a_end_marker_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && r_gend |-> r_gcnt == 2'd1 && !r_gdata && !r_gbad)
        else $error("end marker not a lone result");

    a_u_enters_hex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_mode == jsu_pkg::MODE_ESCAPE && r_in_byte == jsu_pkg::CHAR_U
        |=> r_mode == jsu_pkg::MODE_HEX && r_digits == 2'd0)
        else $error("\\u did not start hex gathering");

    a_accept_loads_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_in_vld)
        else $error("accepted byte not held in input register");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && n_gcnt != 2'd0 |-> r_gcnt == 2'd0 || (out_fire && r_gcnt == 2'd1))
        else $error("result group overwritten before delivery");
`endif

endmodule

FILE: dv/tb_json_string_unescaper.sv
// self-checking testbench for json_string_unescaper: directed and random string bodies,
// a predicting scoreboard class, random idling on both channels and a long result hold-off
// depends on jsu_pkg and the stream interfaces in jsu_if
`timescale 1ns / 1ps

typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_end;
    logic       bad_hex;
    logic       last;
} t_decoded;

class unescape_scoreboard;
    localparam int MAX_REPORTS = 40;

    jsu_pkg::t_mode mode;
    logic [1:0]     digits_seen;
    logic [15:0]    code_unit;
    logic           hex_bad;
    logic [7:0]     replacement;
    t_decoded       staged[$];
    t_decoded       expected_q[$];
    int             errors;

    function new();
        mode        = jsu_pkg::MODE_NORMAL;
        digits_seen = 2'd0;
        code_unit   = 16'd0;
        hex_bad     = 1'b0;
        replacement = jsu_pkg::UNKNOWN_ESC_RESET;
        errors      = 0;
    endfunction

    // {ok, nibble}
    static function logic [4:0] hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") return {1'b1, c[3:0]};
        if (c >= "a" && c <= "f") return {1'b1, 4'(c - 8'h57)};
        if (c >= "A" && c <= "F") return {1'b1, 4'(c - 8'h37)};
        return 5'd0;
    endfunction

    function void set_replacement(input logic [7:0] value);
        replacement = value;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void stage(input logic [7:0] b, input logic v, input logic e, input logic bad);
        t_decoded r;
        r.out_byte   = b;
        r.byte_valid = v;
        r.string_end = e;
        r.bad_hex    = bad;
        r.last       = 1'b0;
        staged.push_back(r);
    endfunction

    function void note_input(input logic [7:0] c);
        logic [4:0] digit;
        logic [7:0] mapped;
        case (mode)
            jsu_pkg::MODE_ESCAPE: begin
                if (c == jsu_pkg::CHAR_U) begin
                    mode        = jsu_pkg::MODE_HEX;
                    digits_seen = 2'd0;
                    code_unit   = 16'd0;
                    hex_bad     = 1'b0;
                end else begin
                    mode = jsu_pkg::MODE_NORMAL;
                    case (c)
                        jsu_pkg::CHAR_QUOTE, jsu_pkg::CHAR_BSLASH,
                        jsu_pkg::CHAR_SLASH: mapped = c;
                        jsu_pkg::CHAR_B:  mapped = jsu_pkg::CTRL_BS;
                        jsu_pkg::CHAR_F:  mapped = jsu_pkg::CTRL_FF;
                        jsu_pkg::CHAR_N:  mapped = jsu_pkg::CTRL_LF;
                        jsu_pkg::CHAR_R:  mapped = jsu_pkg::CTRL_CR;
                        jsu_pkg::CHAR_T:  mapped = jsu_pkg::CTRL_HT;
                        default: mapped = replacement;
                    endcase
                    stage(mapped, 1'b1, 1'b0, 1'b0);
                end
            end
            jsu_pkg::MODE_HEX: begin
                digit = hex_digit(c);
                if (!digit[4]) hex_bad = 1'b1;
                code_unit = {code_unit[11:0], digit[3:0]};
                if (digits_seen != 2'd3) begin
                    digits_seen = digits_seen + 2'd1;
                end else begin
                    if (code_unit < 16'h0080) begin
                        stage(code_unit[7:0], 1'b1, 1'b0, hex_bad);
                    end else if (code_unit < 16'h0800) begin
                        stage({3'b110, code_unit[10:6]}, 1'b1, 1'b0, hex_bad);
                        stage({2'b10, code_unit[5:0]}, 1'b1, 1'b0, hex_bad);
                    end else begin
                        stage({4'b1110, code_unit[15:12]}, 1'b1, 1'b0, hex_bad);
                        stage({2'b10, code_unit[11:6]}, 1'b1, 1'b0, hex_bad);
                        stage({2'b10, code_unit[5:0]}, 1'b1, 1'b0, hex_bad);
                    end
                    mode        = jsu_pkg::MODE_NORMAL;
                    digits_seen = 2'd0;
                    code_unit   = 16'd0;
                    hex_bad     = 1'b0;
                end
            end
            default: begin
                mode = jsu_pkg::MODE_NORMAL;
                if (c == jsu_pkg::CHAR_BSLASH) begin
                    mode = jsu_pkg::MODE_ESCAPE;
                end else if (c == jsu_pkg::CHAR_QUOTE) begin
                    stage(8'h00, 1'b0, 1'b1, 1'b0);
                end else begin
                    stage(c, 1'b1, 1'b0, 1'b0);
                end
            end
        endcase
        if (staged.size() > 0) staged[staged.size() - 1].last = 1'b1;
        foreach (staged[i]) expected_q.push_back(staged[i]);
        staged.delete();
    endfunction

    task report(input string what);
        errors++;
        if (errors <= MAX_REPORTS) $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task check_result(input t_decoded got);
        t_decoded want;
        if (expected_q.size() == 0) begin
            report($sformatf("unexpected result %02h valid %b end %b bad %b last %b",
                             got.out_byte, got.byte_valid, got.string_end, got.bad_hex,
                             got.last));
            return;
        end
        want = expected_q.pop_front();
        if (got.out_byte !== want.out_byte)
            report($sformatf("out_byte %02h, expected %02h", got.out_byte, want.out_byte));
        if (got.byte_valid !== want.byte_valid)
            report($sformatf("byte_valid %b, expected %b", got.byte_valid, want.byte_valid));
        if (got.string_end !== want.string_end)
            report($sformatf("string_end %b, expected %b", got.string_end, want.string_end));
        if (got.bad_hex !== want.bad_hex)
            report($sformatf("bad_hex %b, expected %b", got.bad_hex, want.bad_hex));
        if (got.last !== want.last)
            report($sformatf("last %b, expected %b", got.last, want.last));
    endtask
endclass

module tb_json_string_unescaper;
    localparam int ITEMS_PER_PHASE = 82;
    localparam int LONG_HOLD       = 48;
    localparam int SETTLE_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT  = 1000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [7:0] i_cfg_data;

    jsu_in_if  in_if();
    jsu_out_if out_if();

    unescape_scoreboard sb = new();

    int tx_count    = 0;
    bit tx_gaps_on  = 1'b1;
    bit rx_gaps_on  = 1'b1;
    bit rx_hold_req = 1'b0;

    json_string_unescaper DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = (tx_gaps_on && $urandom_range(0, 99) < 25) ? pick_gap() : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.in_byte <= b;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        sb.note_input(b);
        tx_count++;
    endtask

    task automatic send_random_sequence();
        logic [7:0]    escapes [8];
        logic [15:0]   unit;
        logic [3:0]    nib;
        logic [7:0]    ch;
        jsu_pkg::t_hex hx;
        int            kind;
        int            bad_pos;
        escapes = '{jsu_pkg::CHAR_QUOTE, jsu_pkg::CHAR_BSLASH, jsu_pkg::CHAR_SLASH,
                    jsu_pkg::CHAR_B, jsu_pkg::CHAR_F, jsu_pkg::CHAR_N, jsu_pkg::CHAR_R,
                    jsu_pkg::CHAR_T};
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            send_byte(8'($urandom_range(0, 255)));
        end else if (kind < 45) begin
            send_byte(jsu_pkg::CHAR_BSLASH);
            send_byte(escapes[$urandom_range(0, 7)]);
        end else if (kind < 52) begin
            send_byte(jsu_pkg::CHAR_BSLASH);
            send_byte(8'($urandom_range(0, 255)));
        end else if (kind < 80) begin
            case ($urandom_range(0, 3))
                0: unit = 16'($urandom_range(16'h0000, 16'h007F));
                1: unit = 16'($urandom_range(16'h0080, 16'h07FF));
                2: unit = 16'($urandom_range(16'h0800, 16'hFFFF));
                default: begin
                    case ($urandom_range(0, 3))
                        0: unit = 16'h007F;
                        1: unit = 16'h0080;
                        2: unit = 16'h07FF;
                        default: unit = 16'h0800;
                    endcase
                end
            endcase
            bad_pos = ($urandom_range(0, 99) < 15) ? $urandom_range(0, 3) : -1;
            send_byte(jsu_pkg::CHAR_BSLASH);
            send_byte(jsu_pkg::CHAR_U);
            for (int i = 3; i >= 0; i--) begin
                nib = unit[i*4 +: 4];
                if (i == bad_pos) begin
                    if ($urandom_range(0, 2) == 0) begin
                        ch = jsu_pkg::CHAR_QUOTE;
                    end else begin
                        do begin
                            ch = 8'($urandom_range(0, 255));
                            hx = jsu_pkg::hex_value(ch);
                        end while (hx.ok);
                    end
                end else if (nib < 4'd10) begin
                    ch = 8'h30 + {4'h0, nib};
                end else begin
                    ch = ($urandom_range(0, 1) ? 8'h61 : 8'h41) + {4'h0, nib} - 8'd10;
                end
                send_byte(ch);
            end
        end else if (kind < 90) begin
            send_byte(jsu_pkg::CHAR_QUOTE);
        end else begin
            // noise and cut-off sequences
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_replacement(input logic [7:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_replacement(value);
    endtask

    task automatic run_random_phase();
        int start;
        start = tx_count;
        while (tx_count - start < ITEMS_PER_PHASE) send_random_sequence();
        in_if.valid <= 1'b0;
    endtask

    // result side: check every transaction, then choose ready for the next edge
    initial begin
        t_decoded got;
        int       stall_left;
        stall_left = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
                got.out_byte   = out_if.out_byte;
                got.byte_valid = out_if.byte_valid;
                got.string_end = out_if.string_end;
                got.bad_hex    = out_if.bad_hex;
                got.last       = out_if.last;
                sb.check_result(got);
            end
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                stall_left  = LONG_HOLD;
            end else if (stall_left == 0 && rx_gaps_on && $urandom_range(0, 99) < 20) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
                (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("json_string_unescaper regression: fail");
        $finish;
    end

    initial begin
        string directed;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_data    <= 8'h00;
        in_if.valid   <= 1'b0;
        in_if.in_byte <= 8'h00;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // escaped backslash, unknown escape, one- and three-byte units,
        // then a two-byte unit with a quote standing in for a digit
        directed = "\\\\\\z\\u0041\\uFfFf\\u0\"FF";
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(jsu_pkg::CHAR_QUOTE);
        for (int i = 0; i < directed.len(); i++) send_byte(directed[i]);
        in_if.valid <= 1'b0;
        wait_drained();

        // no idling on either side
        write_replacement(8'h00);
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        run_random_phase();
        wait_drained();

        write_replacement(8'hFF);
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
        run_random_phase();
        wait_drained();

        // long result hold-off while the sender keeps offering back to back
        write_replacement(8'($urandom_range(1, 254)));
        tx_gaps_on  = 1'b0;
        rx_hold_req = 1'b1;
        run_random_phase();
        wait_drained();

        if (sb.errors == 0) begin
            $display("json_string_unescaper regression: pass");
        end else begin
            $display("json_string_unescaper regression: fail");
        end
        $finish;
    end
endmodule
